/* rtl/cbmi_pkg.sv */
package cbmi_pkg;

    // Register decode: CPU address bits 15..13 and 0.
    localparam logic [15:0] ADDR_DECODE_MASK = 16'hE001;
    localparam logic [15:0] ADDR_SELECT      = 16'h8000;
    localparam logic [15:0] ADDR_BANK_DATA   = 16'hA000;
    localparam logic [15:0] ADDR_HIGH_BITS   = 16'hC000;
    localparam logic [15:0] ADDR_MODE        = 16'hE000;

    localparam int unsigned NUM_BANK_REGS = 8;
    localparam int unsigned NUM_PRG_BANKS = 2;

    // Bank register slots with a fixed meaning.
    localparam int unsigned SLOT_HIGH = 0;
    localparam int unsigned SLOT_MODE = 1;

    // Mode register bits.
    localparam int unsigned MODE_MIRROR  = 0;
    localparam int unsigned MODE_HIGH_EN = 1;

    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned OUT_TDATA_W = 96;

    typedef enum logic [1:0] {
        CFG_PRG_LIMIT    = 2'd0,
        CFG_CHR_2K_LIMIT = 2'd1,
        CFG_CHR_1K_LIMIT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]                         select_index;
        logic [NUM_BANK_REGS-1:0][7:0]      bank_regs;
        logic [NUM_PRG_BANKS-1:0][7:0]      prg_banks;
    } state_t;

    typedef struct packed {
        logic [7:0] prg_limit;
        logic [7:0] chr_2k_limit;
        logic [8:0] chr_1k_limit;
    } limits_t;

    typedef struct packed {
        logic [7:0]      prg_bank_first;
        logic [7:0]      prg_bank_second;
        logic [7:0][8:0] chr_window;
        logic            mirror_horizontal;
    } result_t;

    // A bank number above its limit is ANDed with the limit.
    function automatic logic [7:0] limit8(input logic [7:0] v, input logic [7:0] lim);
        return (v > lim) ? (v & lim) : v;
    endfunction

    function automatic logic [8:0] limit9(input logic [8:0] v, input logic [8:0] lim);
        return (v > lim) ? (v & lim) : v;
    endfunction

endpackage

/* rtl/cartridge_bank_mapper_indexed.sv */
// Accepted requests pass through the request register and then the result register to m_axis.
// Throughput: one request per cycle; the request register and the result
// register each advance whenever the result register is free or being taken.
// Reset (rst_n low, asynchronous): both stages empty, all bank registers zero,
// vertical mirroring, limits back to their maximum values.
module cartridge_bank_mapper_indexed (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] bus_address, [23:16] write_data
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] prg_bank_first, [15:8] prg_bank_second, [24:16] chr_window0,
    // [33:25] chr_window1, [42:34] chr_window2, [51:43] chr_window3,
    // [60:52] chr_window4, [69:61] chr_window5, [78:70] chr_window6,
    // [87:79] chr_window7, [88] mirror_horizontal, [95:89] zero
    output logic [95:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    logic              in_valid_reg;
    logic [15:0]       in_addr_reg;
    logic [7:0]        in_data_reg;
    logic              out_valid_reg;
    cbmi_pkg::result_t out_reg;
    cbmi_pkg::limits_t limits_reg;

    logic              advance;
    cbmi_pkg::state_t  state_upd;
    cbmi_pkg::result_t result;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.prg_limit    <= 8'hFF;
            limits_reg.chr_2k_limit <= 8'hFF;
            limits_reg.chr_1k_limit <= 9'h1FF;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                cbmi_pkg::CFG_PRG_LIMIT:    limits_reg.prg_limit    <= cfg_data[7:0];
                cbmi_pkg::CFG_CHR_2K_LIMIT: limits_reg.chr_2k_limit <= cfg_data[7:0];
                cbmi_pkg::CFG_CHR_1K_LIMIT: limits_reg.chr_1k_limit <= cfg_data;
                default:                    limits_reg              <= limits_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_addr_reg <= s_axis_tdata[15:0];
            in_data_reg <= s_axis_tdata[23:16];
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    cbmi_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (advance),
        .bus_address (in_addr_reg),
        .write_data  (in_data_reg),
        .prg_limit   (limits_reg.prg_limit),
        .state_upd   (state_upd)
    );

    cbmi_banks u_banks (
        .state_cur (state_upd),
        .limits    (limits_reg),
        .result    (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0,
                            out_reg.mirror_horizontal,
                            out_reg.chr_window[7],
                            out_reg.chr_window[6],
                            out_reg.chr_window[5],
                            out_reg.chr_window[4],
                            out_reg.chr_window[3],
                            out_reg.chr_window[2],
                            out_reg.chr_window[1],
                            out_reg.chr_window[0],
                            out_reg.prg_bank_second,
                            out_reg.prg_bank_first};

endmodule

/* rtl/cbmi_regs.sv */
module cbmi_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [15:0]          bus_address,
    input  logic [7:0]           write_data,
    input  logic [7:0]           prg_limit,
    output cbmi_pkg::state_t     state_upd
);

    cbmi_pkg::state_t state_reg;
    cbmi_pkg::state_t state_next;

    // Next state as it stands after the current write.
    always_comb
    begin
        state_next = state_reg;
        case (bus_address & cbmi_pkg::ADDR_DECODE_MASK)
            cbmi_pkg::ADDR_SELECT:
            begin
                state_next.select_index = write_data[2:0];
            end
            cbmi_pkg::ADDR_BANK_DATA:
            begin
                if (state_reg.select_index[2:1] == 2'b00)
                begin
                    state_next.prg_banks[state_reg.select_index[0]] =
                        cbmi_pkg::limit8(write_data, prg_limit);
                end
                else if (state_reg.select_index[2] == 1'b0)
                begin
                    // 2K slots keep the bank number in 2K units.
                    state_next.bank_regs[state_reg.select_index] = {1'b0, write_data[7:1]};
                end
                else
                begin
                    state_next.bank_regs[state_reg.select_index] = write_data;
                end
            end
            cbmi_pkg::ADDR_HIGH_BITS:
            begin
                state_next.bank_regs[cbmi_pkg::SLOT_HIGH] = write_data;
            end
            cbmi_pkg::ADDR_MODE:
            begin
                state_next.bank_regs[cbmi_pkg::SLOT_MODE] = write_data;
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (wr_en)
        begin
            state_reg <= state_next;
        end
    end

    assign state_upd = wr_en ? state_next : state_reg;

endmodule

/* rtl/cbmi_banks.sv */
module cbmi_banks (
    input  cbmi_pkg::state_t   state_cur,
    input  cbmi_pkg::limits_t  limits,
    output cbmi_pkg::result_t  result
);

    logic [7:0] high;
    logic [7:0] chr_2k_a;
    logic [7:0] chr_2k_b;
    logic [3:0][8:0] chr_1k;

    always_comb
    begin
        high = state_cur.bank_regs[cbmi_pkg::SLOT_MODE][cbmi_pkg::MODE_HIGH_EN]
             ? state_cur.bank_regs[cbmi_pkg::SLOT_HIGH] : 8'd0;

        chr_2k_a = cbmi_pkg::limit8({high[2] | state_cur.bank_regs[2][7],
                                     state_cur.bank_regs[2][6:0]},
                                    limits.chr_2k_limit);
        chr_2k_b = cbmi_pkg::limit8({high[3] | state_cur.bank_regs[3][7],
                                     state_cur.bank_regs[3][6:0]},
                                    limits.chr_2k_limit);

        // High byte bits 4..7 supply bit 8 of the 1K banks 4..7.
        for (int i = 0; i < 4; i++)
        begin
            chr_1k[i] = cbmi_pkg::limit9({high[4+i], state_cur.bank_regs[4+i]},
                                         limits.chr_1k_limit);
        end

        result.prg_bank_first    = state_cur.prg_banks[0];
        result.prg_bank_second   = state_cur.prg_banks[1];
        result.chr_window[0]     = {chr_2k_a, 1'b0};
        result.chr_window[1]     = {chr_2k_a, 1'b1};
        result.chr_window[2]     = {chr_2k_b, 1'b0};
        result.chr_window[3]     = {chr_2k_b, 1'b1};
        result.chr_window[4]     = chr_1k[0];
        result.chr_window[5]     = chr_1k[1];
        result.chr_window[6]     = chr_1k[2];
        result.chr_window[7]     = chr_1k[3];
        result.mirror_horizontal =
            state_cur.bank_regs[cbmi_pkg::SLOT_MODE][cbmi_pkg::MODE_MIRROR];
    end

endmodule

/* rtl/cbmi_checker.sv */
module cbmi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata
);

    // A result that is not taken stays offered with the same contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped or changed while stalled");

    // The input side only stalls when both stages are full and the output is blocked.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output back-pressure");

    // Every accepted request has a result offered once it has passed through the request register.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |-> ##2 m_axis_tvalid)
        else $error("result missing two cycles after a request");

    // Windows of a 2K bank are its even and odd 1K halves; padding stays zero.
    a_window_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[16] == 1'b0 && m_axis_tdata[25] == 1'b1
                           && m_axis_tdata[33:26] == m_axis_tdata[24:17]
                           && m_axis_tdata[95:89] == 7'd0))
        else $error("2K pattern window pair or padding malformed");

endmodule

bind cartridge_bank_mapper_indexed cbmi_checker u_cbmi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
